### rtl/core/prfd_pkg.sv
// prfd_pkg: shared types and constants of the poll reply frame decoder
// no dependencies; imported by prfd_crc_unit and poll_reply_frame_decoder
`default_nettype none

package prfd_pkg;

   localparam int HEADER_BYTES = 4;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  DEST_BROADCAST = 8'hFF;

   localparam logic [6:0] DIGITAL_MAX = 7'd80;
   localparam logic [3:0] ANALOG_MAX  = 4'd8;

   // transaction opcodes
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_ABORT = 1'b1;

   // result kinds
   localparam logic [2:0] KIND_DIGITAL     = 3'd0;
   localparam logic [2:0] KIND_ANALOG      = 3'd1;
   localparam logic [2:0] KIND_IDENT       = 3'd2;
   localparam logic [2:0] KIND_UNKNOWN_SRC = 3'd3;
   localparam logic [2:0] KIND_CRC_ERROR   = 3'd4;
   localparam logic [2:0] KIND_NOT_ADDR    = 3'd5;
   localparam logic [2:0] KIND_UNKNOWN_FN  = 3'd6;
   localparam logic [2:0] KIND_LEN_ERROR   = 3'd7;

   // csr register indexes
   localparam logic [2:0] CSR_DIGITAL_COUNT = 3'd0;
   localparam logic [2:0] CSR_ANALOG_COUNT  = 3'd1;
   localparam logic [2:0] CSR_CODE_IDENT    = 3'd2;
   localparam logic [2:0] CSR_CODE_DIGITAL  = 3'd3;
   localparam logic [2:0] CSR_CODE_ANALOG   = 3'd4;

   typedef struct packed {
      logic       init;
      logic       start;
      logic [7:0] data;
   } crc_ctrl_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] index;
      logic [9:0] value;
      logic [3:0] valid_bits;
      logic       answered;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

### rtl/core/prfd_ram.sv
// prfd_ram: generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none

module prfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 12
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/prfd_crc_unit.sv
// prfd_crc_unit: bit-serial crc-16 (reflected poly a001), one bit per cycle
// depends on prfd_pkg
`default_nettype none

module prfd_crc_unit
   import prfd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire crc_ctrl_type ctrl,
   output logic [15:0]       crc,
   output logic              busy
);

   logic [15:0] crc_ff, crc_in;
   logic [3:0]  cnt_ff, cnt_in;

   always_comb begin
      crc_in = crc_ff;
      cnt_in = cnt_ff;
      if (ctrl.init) begin
         crc_in = CRC_INIT;
         cnt_in = 4'd0;
      end else if (ctrl.start) begin
         crc_in = crc_ff ^ {8'h00, ctrl.data};
         cnt_in = 4'd8;
      end else if (cnt_ff != 4'd0) begin
         crc_in = (crc_ff >> 1) ^ (crc_ff[0] ? CRC_POLY : 16'h0000);
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
         cnt_ff <= 4'd0;
      end else begin
         crc_ff <= crc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign crc  = crc_ff;
   assign busy = (cnt_ff != 4'd0);

endmodule

`default_nettype wire

### rtl/core/poll_reply_frame_decoder.sv
// poll_reply_frame_decoder: receives reply frame bytes, checks crc and header, emits results
// depends on prfd_pkg, prfd_ram, prfd_crc_unit
// header and payload bytes: accept, bit-serial crc steps, return to idle; crc bytes and aborts:
// accept only; an oversized length byte: accept, then emit. frame end: a check state, then read and
// output per digital group, two frame store reads and output per analog channel, or emit for a single result.
// results leave through an output register; the next transaction is taken while it waits.
// synchronous reset clears sequencer, byte count, crc, output valid and config registers;
// the frame store is not cleared.
`default_nettype none

module poll_reply_frame_decoder
   import prfd_pkg::*;
#(
   parameter int MAX_DATA = 10
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_opcode,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic [7:0] req_expected_source,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_kind,
   output logic [3:0]      rsp_index,
   output logic [9:0]      rsp_value,
   output logic [3:0]      rsp_valid_bits,
   output logic            rsp_answered,
   output logic            rsp_last,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   localparam int DEPTH  = MAX_DATA + 2;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(HEADER_BYTES + DEPTH + 1);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CRC   = 9'b000000010,
      S_CHECK = 9'b000000100,
      S_DRD   = 9'b000001000,
      S_DOUT  = 9'b000010000,
      S_AHI   = 9'b000100000,
      S_ALO   = 9'b001000000,
      S_AOUT  = 9'b010000000,
      S_EMIT  = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0] dest_ff, dest_in, src_ff, src_in, fn_ff, fn_in, len_ff, len_in;
   logic [7:0] rx_hi_ff, rx_hi_in, rx_lo_ff, rx_lo_in, exp_ff, exp_in;
   logic [6:0] dcount_ff;
   logic [3:0] acount_ff;
   logic [7:0] code_ident_ff, code_dig_ff, code_ana_ff;
   logic [3:0] idx_ff, idx_in;
   logic [6:0] rem_ff, rem_in;
   logic [3:0] acnt_ff, acnt_in;
   logic       ok_ff, ok_in;
   logic [7:0] hi_ff, hi_in;
   result_type res_ff, res_in, out_ff, out_in;
   logic       out_valid_ff, out_valid_in;

   logic              accept, out_free;
   logic [CNT_W-1:0]  pos;
   logic [7:0]        pos8, idx8, lo_idx8;
   logic [6:0]        dcnt_sat;
   logic [3:0]        acnt_sat, valid4;
   logic [7:0]        mask, dig_byte, lo_byte;
   logic [1:0]        lo_bits;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        rd_data;
   crc_ctrl_type      crc_ctrl;
   logic [15:0]       crc_val;
   logic              crc_busy;

   prfd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   prfd_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .crc   (crc_val),
      .busy  (crc_busy)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   assign pos      = count_ff - CNT_W'(HEADER_BYTES);
   assign pos8     = 8'(pos);
   assign idx8     = {4'b0000, idx_ff};
   assign lo_idx8  = {4'b0000, acnt_ff} + {6'b000000, idx_ff[3:2]};
   assign wr_addr  = pos[ADDR_W-1:0];
   assign dcnt_sat = (dcount_ff > DIGITAL_MAX) ? DIGITAL_MAX : dcount_ff;
   assign acnt_sat = (acount_ff > ANALOG_MAX) ? ANALOG_MAX : acount_ff;
   assign valid4   = (rem_ff >= 7'd8) ? 4'd8 : rem_ff[3:0];
   assign mask     = 8'hFF << (4'd8 - valid4);
   assign dig_byte = ok_ff ? rd_data : 8'h00;
   assign lo_byte  = ok_ff ? rd_data : 8'h00;

   always_comb begin
      case (idx_ff[1:0])
         2'd0:    lo_bits = lo_byte[7:6];
         2'd1:    lo_bits = lo_byte[5:4];
         2'd2:    lo_bits = lo_byte[3:2];
         default: lo_bits = lo_byte[1:0];
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dest_in      = dest_ff;
      src_in       = src_ff;
      fn_in        = fn_ff;
      len_in       = len_ff;
      rx_hi_in     = rx_hi_ff;
      rx_lo_in     = rx_lo_ff;
      exp_in       = exp_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      acnt_in      = acnt_ff;
      ok_in        = ok_ff;
      hi_in        = hi_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = idx8[ADDR_W-1:0];
      crc_ctrl     = '{init: 1'b0, start: 1'b0, data: req_rx_byte};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_ABORT) begin
                  count_in      = '0;
                  crc_ctrl.init = 1'b1;
               end else if (count_ff < CNT_W'(HEADER_BYTES)) begin
                  count_in = count_ff + CNT_W'(1);
                  case (count_ff[1:0])
                     2'd0:    dest_in = req_rx_byte;
                     2'd1:    src_in  = req_rx_byte;
                     2'd2:    fn_in   = req_rx_byte;
                     default: len_in  = req_rx_byte;
                  endcase
                  if (count_ff[1:0] == 2'd3 && req_rx_byte > 8'(MAX_DATA)) begin
                     count_in      = '0;
                     crc_ctrl.init = 1'b1;
                     res_in        = '{KIND_LEN_ERROR, 4'd0, 10'd0, 4'd0, 1'b0, 1'b1};
                     state_in      = S_EMIT;
                  end else begin
                     crc_ctrl.start = 1'b1;
                     state_in       = S_CRC;
                  end
               end else begin
                  wr_en = 1'b1;
                  if (pos8 < len_ff) begin
                     crc_ctrl.start = 1'b1;
                     count_in       = count_ff + CNT_W'(1);
                     state_in       = S_CRC;
                  end else if (pos8 == len_ff) begin
                     rx_hi_in = req_rx_byte;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     rx_lo_in = req_rx_byte;
                     exp_in   = req_expected_source;
                     count_in = '0;
                     state_in = S_CHECK;
                  end
               end
            end
         end
         S_CRC: begin
            if (!crc_busy) begin
               state_in = S_IDLE;
            end
         end
         S_CHECK: begin
            crc_ctrl.init = 1'b1;
            state_in      = S_EMIT;
            idx_in        = 4'd0;
            if ({rx_hi_ff, rx_lo_ff} != crc_val) begin
               res_in = '{KIND_CRC_ERROR, 4'd0, 10'd0, 4'd0, 1'b0, 1'b1};
            end else if (dest_ff != DEST_BROADCAST) begin
               res_in = '{KIND_NOT_ADDR, 4'd0, 10'd0, 4'd0, 1'b0, 1'b1};
            end else if (src_ff != exp_ff) begin
               res_in = '{KIND_UNKNOWN_SRC, 4'd0, 10'd0, 4'd0, 1'b1, 1'b1};
            end else if (fn_ff == code_ident_ff) begin
               res_in = '{KIND_IDENT, 4'd0, 10'd0, 4'd0, 1'b1, 1'b1};
            end else if (fn_ff == code_dig_ff) begin
               res_in = '{KIND_DIGITAL, 4'd0, 10'd0, 4'd0, 1'b1, 1'b1};
               rem_in = dcnt_sat;
               if (dcnt_sat != 7'd0) begin
                  state_in = S_DRD;
               end
            end else if (fn_ff == code_ana_ff) begin
               res_in  = '{KIND_ANALOG, 4'd0, 10'd0, 4'd0, 1'b1, 1'b1};
               acnt_in = acnt_sat;
               if (acnt_sat != 4'd0) begin
                  state_in = S_AHI;
               end
            end else begin
               res_in = '{KIND_UNKNOWN_FN, 4'd0, 10'd0, 4'd0, 1'b0, 1'b1};
            end
         end
         S_DRD: begin
            ok_in    = (idx8 < len_ff);
            rd_en    = ok_in;
            state_in = S_DOUT;
         end
         S_DOUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = '{KIND_DIGITAL, idx_ff, {2'b00, ~dig_byte & mask}, valid4, 1'b1,
                          (rem_ff <= 7'd8)};
               rem_in = rem_ff - 7'd8;
               idx_in = idx_ff + 4'd1;
               state_in = (rem_ff <= 7'd8) ? S_IDLE : S_DRD;
            end
         end
         S_AHI: begin
            ok_in    = (idx8 < len_ff);
            rd_en    = ok_in;
            state_in = S_ALO;
         end
         S_ALO: begin
            hi_in    = ok_ff ? rd_data : 8'h00;
            ok_in    = (lo_idx8 < len_ff);
            rd_en    = ok_in;
            rd_addr  = lo_idx8[ADDR_W-1:0];
            state_in = S_AOUT;
         end
         S_AOUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = '{KIND_ANALOG, idx_ff, {hi_ff, lo_bits}, 4'd0, 1'b1,
                          (idx_ff + 4'd1 == acnt_ff)};
               idx_in   = idx_ff + 4'd1;
               state_in = (idx_ff + 4'd1 == acnt_ff) ? S_IDLE : S_AHI;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         dcount_ff     <= 7'd0;
         acount_ff     <= 4'd0;
         code_ident_ff <= 8'd1;
         code_dig_ff   <= 8'd2;
         code_ana_ff   <= 8'd3;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DIGITAL_COUNT: dcount_ff     <= csr_wdata[6:0];
               CSR_ANALOG_COUNT:  acount_ff     <= csr_wdata[3:0];
               CSR_CODE_IDENT:    code_ident_ff <= csr_wdata;
               CSR_CODE_DIGITAL:  code_dig_ff   <= csr_wdata;
               CSR_CODE_ANALOG:   code_ana_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      dest_ff  <= dest_in;
      src_ff   <= src_in;
      fn_ff    <= fn_in;
      len_ff   <= len_in;
      rx_hi_ff <= rx_hi_in;
      rx_lo_ff <= rx_lo_in;
      exp_ff   <= exp_in;
      idx_ff   <= idx_in;
      rem_ff   <= rem_in;
      acnt_ff  <= acnt_in;
      ok_ff    <= ok_in;
      hi_ff    <= hi_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_ff.kind;
   assign rsp_index      = out_ff.index;
   assign rsp_value      = out_ff.value;
   assign rsp_valid_bits = out_ff.valid_bits;
   assign rsp_answered   = out_ff.answered;
   assign rsp_last       = out_ff.last;

   a_crc_busy_in_crc_state: assert property (@(posedge clock) disable iff (reset)
      crc_busy |-> state_ff == S_CRC)
      else $error("crc unit busy outside crc state");

   a_answered_matches_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.answered == (out_ff.kind <= KIND_UNKNOWN_SRC))
      else $error("answered flag does not match result kind");

   a_length_in_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(HEADER_BYTES)) |-> len_ff <= 8'(MAX_DATA))
      else $error("stored frame length beyond store");

   a_digital_remaining: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DOUT) |-> rem_ff != 7'd0)
      else $error("digital group emitted with no inputs left");

endmodule

`default_nettype wire
